// ===== hw/rtl/cbpt_pkg.sv =====
// Package for the cubic Bezier point and tangent evaluator.
// Holds the stage counts and fixed sizes shared by every file; depends on nothing.
package cbpt_pkg;

    // Register stages inside one interpolation unit and inside one rounding unit.
    localparam int LERP_LAT  = 3;
    localparam int ROUND_LAT = 2;

    // Three coordinates per point and four control points per curve segment.
    localparam int NUM_AXES = 3;
    localparam int NUM_CTRL = 4;

endpackage

// ===== hw/rtl/cubic_bezier_point_tangent_top.sv =====
// Cubic Bezier point and tangent evaluator, top level; uses cbpt_pkg, cbpt_lerp, cbpt_round.
// The done strobe follows the accepting edge through the input register, three
// interpolation levels of 3 stages each and 2 rounding stages. Throughput: one item per cycle,
// set by the fully pipelined interpolation units; busy is always low.
// Reset clears only the valid bits; no curve state is kept, and results cannot be held off.
module cubic_bezier_point_tangent_top
    import cbpt_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [FRAC_BITS:0]             t_param,
    input  logic [3*COORD_BITS-1:0]        ctrl_a,
    input  logic [3*COORD_BITS-1:0]        ctrl_b,
    input  logic [3*COORD_BITS-1:0]        ctrl_c,
    input  logic [3*COORD_BITS-1:0]        ctrl_d,
    output logic                           done,
    output logic signed [COORD_BITS-1:0]   point_x,
    output logic signed [COORD_BITS-1:0]   point_y,
    output logic signed [COORD_BITS-1:0]   point_z,
    output logic signed [COORD_BITS+2:0]   slope_x,
    output logic signed [COORD_BITS+2:0]   slope_y,
    output logic signed [COORD_BITS+2:0]   slope_z
);

    // The curve is evaluated by de Casteljau's construction: three levels of exact
    // linear interpolation between neighbouring points. Each level widens the value
    // by FRAC_BITS bits, so nothing is lost before the single final rounding.
    // The tangent comes for free from the second level: B'(t) = 3 * (r2 - r1),
    // where r1 and r2 are the two points left after two interpolation levels.

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int TW  = C + 2*F + 3;
    localparam int LAT = 1 + 3*LERP_LAT + ROUND_LAT;
    localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

    logic                 accept;
    logic                 in_vld_reg;
    logic [F:0]           t_in_reg;
    logic [F:0]           t_in_next;
    logic [3*C-1:0]       ctrl_reg [NUM_CTRL];
    logic [F:0]           t_dly_reg [2*LERP_LAT];

    logic signed [C-1:0]   pt   [NUM_AXES];
    logic signed [C+2:0]   sl   [NUM_AXES];
    logic [NUM_AXES-1:0]   lane_vld;
    logic [NUM_AXES-1:0]   tan_vld;

    // The pipeline never stalls, so a new item is taken in every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // A parameter above 1.0 is taken as exactly 1.0.
    assign t_in_next = (t_param > T_ONE) ? T_ONE : t_param;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        t_in_reg    <= t_in_next;
        ctrl_reg[0] <= ctrl_a;
        ctrl_reg[1] <= ctrl_b;
        ctrl_reg[2] <= ctrl_c;
        ctrl_reg[3] <= ctrl_d;
    end

    // The parameter travels beside the data so that each interpolation level sees
    // the t of its own item.
    always_ff @(posedge clk)
    begin
        t_dly_reg[0] <= t_in_reg;
        for (int i = 1; i < 2*LERP_LAT; i++)
        begin
            t_dly_reg[i] <= t_dly_reg[i-1];
        end
    end

    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_axis
        logic signed [C-1:0]     pc [NUM_CTRL];
        logic signed [C+F-1:0]   q1 [NUM_CTRL-1];
        logic signed [C+2*F-1:0] r1;
        logic signed [C+2*F-1:0] r2;
        logic signed [C+3*F-1:0] pw;
        logic                    lv1;
        logic                    lv2;
        logic                    lv3;
        logic signed [C+2*F:0]   diff_reg;
        logic signed [TW-1:0]    tri_reg;
        logic signed [TW-1:0]    tdl_reg;

        for (genvar i = 0; i < NUM_CTRL; i++)
        begin : g_coord
            assign pc[i] = ctrl_reg[i][k*C +: C];
        end

        // First level: three blends of neighbouring control points.
        cbpt_lerp #(.W(C), .F(F)) u_l1a
        (
            .clk(clk), .rst_n(rst_n), .vld_i(in_vld_reg), .t(t_in_reg),
            .a(pc[0]), .b(pc[1]), .vld_o(lv1), .q(q1[0])
        );
        cbpt_lerp #(.W(C), .F(F)) u_l1b
        (
            .clk(clk), .rst_n(rst_n), .vld_i(in_vld_reg), .t(t_in_reg),
            .a(pc[1]), .b(pc[2]), .vld_o(), .q(q1[1])
        );
        cbpt_lerp #(.W(C), .F(F)) u_l1c
        (
            .clk(clk), .rst_n(rst_n), .vld_i(in_vld_reg), .t(t_in_reg),
            .a(pc[2]), .b(pc[3]), .vld_o(), .q(q1[2])
        );

        // Second level: two points whose difference is the tangent direction.
        cbpt_lerp #(.W(C+F), .F(F)) u_l2a
        (
            .clk(clk), .rst_n(rst_n), .vld_i(lv1), .t(t_dly_reg[LERP_LAT-1]),
            .a(q1[0]), .b(q1[1]), .vld_o(lv2), .q(r1)
        );
        cbpt_lerp #(.W(C+F), .F(F)) u_l2b
        (
            .clk(clk), .rst_n(rst_n), .vld_i(lv1), .t(t_dly_reg[LERP_LAT-1]),
            .a(q1[1]), .b(q1[2]), .vld_o(), .q(r2)
        );

        // Third level: the curve point, scaled by 2^(3F).
        cbpt_lerp #(.W(C+2*F), .F(F)) u_l3
        (
            .clk(clk), .rst_n(rst_n), .vld_i(lv2), .t(t_dly_reg[2*LERP_LAT-1]),
            .a(r1), .b(r2), .vld_o(lv3), .q(pw)
        );

        // Tangent path, scaled by 2^(2F): difference, times three, then one delay
        // stage so that it meets the point at the rounding units.
        always_ff @(posedge clk)
        begin
            diff_reg <= (C+2*F+1)'(r2) - (C+2*F+1)'(r1);
            tri_reg  <= (TW'(diff_reg) <<< 1) + TW'(diff_reg);
            tdl_reg  <= tri_reg;
        end

        cbpt_round #(.IN_W(C+3*F), .SHIFT(3*F), .OUT_W(C)) u_rnd_pt
        (
            .clk(clk), .rst_n(rst_n), .vld_i(lv3), .x(pw),
            .vld_o(lane_vld[k]), .q(pt[k])
        );
        cbpt_round #(.IN_W(TW), .SHIFT(2*F), .OUT_W(C+3)) u_rnd_sl
        (
            .clk(clk), .rst_n(rst_n), .vld_i(lv3), .x(tdl_reg),
            .vld_o(tan_vld[k]), .q(sl[k])
        );
    end

    assign done    = lane_vld[0];
    assign point_x = pt[0];
    assign point_y = pt[1];
    assign point_z = pt[2];
    assign slope_x = sl[0];
    assign slope_y = sl[1];
    assign slope_z = sl[2];

    // Every result goes back to exactly one item taken a fixed latency earlier.
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without an item accepted %0d cycles before", LAT);

    // All three coordinate lanes and both result paths must stay in step.
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_vld == tan_vld) && ((lane_vld == '0) || (&lane_vld)))
        else $error("coordinate lanes or point and tangent paths out of step");

    // The clamp must keep the parameter within [0, 1.0] for every item in flight.
    a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |-> (t_in_reg <= T_ONE))
        else $error("curve parameter above 1.0 entered the pipeline");

endmodule

// ===== hw/rtl/cbpt_lerp.sv =====
// Pipelined exact linear interpolation s*a + t*b with s = 2^F - t.
// Depends on cbpt_pkg for the stage count.
module cbpt_lerp
    import cbpt_pkg::*;
#(
    parameter int W = 16,
    parameter int F = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vld_i,
    input  logic [F:0]            t,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic                  vld_o,
    output logic signed [W+F-1:0] q
);

    // s*a + t*b is rewritten as a*2^F + t*(b - a), which needs a single product.
    // The difference is split into a low and a high half so that each multiplier
    // stays narrow.
    localparam int DW = W + 1;
    localparam int LO = DW / 2;
    localparam int HW = DW - LO;
    localparam int SW = W + F + 3;

    logic signed [DW-1:0]     d_reg;
    logic signed [DW-1:0]     d_next;
    logic signed [W-1:0]      a0_reg;
    logic signed [W-1:0]      a1_reg;
    logic [F:0]               t0_reg;
    logic [F+LO:0]            plo_reg;
    logic [F+LO:0]            plo_next;
    logic signed [F+HW+1:0]   phi_reg;
    logic signed [F+HW+1:0]   phi_next;
    logic signed [W+F-1:0]    q_reg;
    logic signed [W+F-1:0]    q_next;
    logic signed [SW-1:0]     ext_a;
    logic signed [SW-1:0]     ext_hi;
    logic signed [SW-1:0]     ext_lo;
    logic signed [SW-1:0]     sum;
    logic [LERP_LAT-1:0]      vld_reg;

    always_comb
    begin
        d_next   = DW'(b) - DW'(a);
        plo_next = (F+LO+1)'(t0_reg) * (F+LO+1)'(d_reg[LO-1:0]);
        phi_next = (F+HW+2)'($signed({1'b0, t0_reg}))
                 * (F+HW+2)'($signed(d_reg[DW-1:LO]));
        ext_a    = SW'(a1_reg) <<< F;
        ext_hi   = SW'(phi_reg) <<< LO;
        ext_lo   = SW'($signed({1'b0, plo_reg}));
        sum      = ext_a + ext_hi + ext_lo;
        // The result is a convex blend of a and b, so it always fits W+F bits.
        q_next   = sum[W+F-1:0];
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        a0_reg  <= a;
        t0_reg  <= t;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        a1_reg  <= a0_reg;
        q_reg   <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LERP_LAT-2:0], vld_i};
        end
    end

    assign q     = q_reg;
    assign vld_o = vld_reg[LERP_LAT-1];

endmodule

// ===== hw/rtl/cbpt_round.sv =====
// Two-stage round to nearest (ties upward) by a power of two, then saturation.
// Depends on cbpt_pkg for the stage count.
module cbpt_round
    import cbpt_pkg::*;
#(
    parameter int IN_W  = 64,
    parameter int SHIFT = 48,
    parameter int OUT_W = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    vld_i,
    input  logic signed [IN_W-1:0]  x,
    output logic                    vld_o,
    output logic signed [OUT_W-1:0] q
);

    localparam int QW = IN_W + 1 - SHIFT;
    localparam logic signed [IN_W:0] HALF =
        {{(IN_W+1-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] MAX_V = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] MIN_V = {1'b1, {(OUT_W-1){1'b0}}};

    logic signed [IN_W:0]    y_reg;
    logic signed [IN_W:0]    y_next;
    logic [QW-1:0]           fl;
    logic [QW-OUT_W:0]       top_bits;
    logic signed [OUT_W-1:0] q_reg;
    logic signed [OUT_W-1:0] q_next;
    logic [ROUND_LAT-1:0]    vld_reg;

    always_comb
    begin
        y_next   = (IN_W+1)'(x) + HALF;
        // Taking the upper bits of a two's complement value is a floor division.
        fl       = y_reg[IN_W:SHIFT];
        top_bits = fl[QW-1:OUT_W-1];
        if ((&top_bits) || !(|top_bits))
        begin
            q_next = fl[OUT_W-1:0];
        end
        else if (fl[QW-1])
        begin
            q_next = MIN_V;
        end
        else
        begin
            q_next = MAX_V;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROUND_LAT-2:0], vld_i};
        end
    end

    assign q     = q_reg;
    assign vld_o = vld_reg[ROUND_LAT-1];

endmodule

// ===== sim/cubic_bezier_point_tangent_top_tb.sv =====
// Self-checking testbench for the cubic Bezier point and tangent evaluator.
// Depends on cbpt_pkg and cubic_bezier_point_tangent_top; drives directed then random items
// and compares every done strobe against an exact integer prediction.
`timescale 1ns / 100ps

module cubic_bezier_point_tangent_top_tb
    import cbpt_pkg::*;
();

    // Widths of the default build: 16-bit coordinates, Q1.16 curve parameter.
    localparam int COORD_W = 16;
    localparam int FRAC_W  = 16;
    localparam int SLOPE_W = COORD_W + 3;
    localparam int ONE_Q   = 1 << FRAC_W;

    // Edge-to-strobe latency, reckoned the same way as LAT in the top level.
    localparam int PIPE_LAT = 1 + 3 * LERP_LAT + ROUND_LAT;

    // The watchdog gives up after this many cycles without any item or result moving.
    localparam int STALL_LIMIT = 2000;

    localparam int RANDOM_ITEMS = 400;

    // How the coordinates of a random control point are drawn.
    typedef enum int
    {
        CM_FULL,
        CM_EXTREME,
        CM_SMALL
    } coord_mode_e;

    // One curve sample: point and tangent for x, y and z (index 0 is x).
    typedef struct packed
    {
        logic [2:0][COORD_W-1:0] point;
        logic [2:0][SLOPE_W-1:0] slope;
    } curve_sample_t;

    // Scoreboard: predicts each accepted item exactly and checks the results in order.
    class bezier_scoreboard;
        curve_sample_t expected_samples[$];
        int            failures;
        int            checked;

        function new();
            failures = 0;
            checked  = 0;
        endfunction

        // Floor of (acc + half) / 2^shift, then clipped to a signed range of the given width.
        function logic signed [63:0] round_sat(input logic signed [127:0] acc,
                                               input int shift, input int bits);
            logic signed [127:0] q;
            logic signed [127:0] top;
            q   = (acc + (128'sd1 <<< (shift - 1))) >>> shift;
            top = (128'sd1 <<< (bits - 1)) - 128'sd1;
            if (q > top)
                q = top;
            else if (q < -top - 128'sd1)
                q = -top - 128'sd1;
            return q[63:0];
        endfunction

        // Works out the Bernstein point and derivative of one accepted item.
        function void predict_curve_sample(input logic [FRAC_W:0] t_in,
                                           input logic [3*COORD_W-1:0] p1, p2, p3, p4);
            logic [3*COORD_W-1:0] ctrl [4];
            logic signed [127:0]  tv;
            logic signed [127:0]  sv;
            logic signed [127:0]  pw [4];
            logic signed [127:0]  tw [4];
            logic signed [127:0]  c;
            logic signed [127:0]  pacc;
            logic signed [127:0]  tacc;
            logic signed [63:0]   r;
            curve_sample_t        expect_s;
            ctrl[0] = p1;
            ctrl[1] = p2;
            ctrl[2] = p3;
            ctrl[3] = p4;
            // A parameter above 1.0 is treated as exactly 1.0.
            tv = (t_in > ONE_Q) ? ONE_Q : t_in;
            sv = ONE_Q - tv;
            // Point weights carry a scale of 2^(3*FRAC_W), tangent weights 2^(2*FRAC_W).
            pw[0] = sv * sv * sv;
            pw[1] = 3 * tv * sv * sv;
            pw[2] = 3 * tv * tv * sv;
            pw[3] = tv * tv * tv;
            tw[0] = -3 * sv * sv;
            tw[1] = 3 * sv * (ONE_Q - 3 * tv);
            tw[2] = 3 * tv * (2 * ONE_Q - 3 * tv);
            tw[3] = 3 * tv * tv;
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                pacc = 0;
                tacc = 0;
                for (int i = 0; i < NUM_CTRL; i++)
                begin
                    c    = $signed(ctrl[i][ax*COORD_W +: COORD_W]);
                    pacc = pacc + pw[i] * c;
                    tacc = tacc + tw[i] * c;
                end
                r = round_sat(pacc, 3 * FRAC_W, COORD_W);
                expect_s.point[ax] = r[COORD_W-1:0];
                r = round_sat(tacc, 2 * FRAC_W, SLOPE_W);
                expect_s.slope[ax] = r[SLOPE_W-1:0];
            end
            expected_samples = {expected_samples, expect_s};
        endfunction

        // Compares one result with the oldest outstanding prediction, field by field.
        function void check_curve_sample(input curve_sample_t got);
            curve_sample_t want;
            string         axis_name [3];
            axis_name = '{"x", "y", "z"};
            if (expected_samples.size() == 0)
            begin
                $error("result strobe with no item outstanding");
                failures++;
                return;
            end
            want = expected_samples.pop_front();
            checked++;
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                if (got.point[ax] !== want.point[ax])
                begin
                    $error("point_%s: expected %0d, actual %0d", axis_name[ax],
                           $signed(want.point[ax]), $signed(got.point[ax]));
                    failures++;
                end
                if (got.slope[ax] !== want.slope[ax])
                begin
                    $error("slope_%s: expected %0d, actual %0d", axis_name[ax],
                           $signed(want.slope[ax]), $signed(got.slope[ax]));
                    failures++;
                end
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [FRAC_W:0]             t_param;
    logic [3*COORD_W-1:0]        ctrl_a;
    logic [3*COORD_W-1:0]        ctrl_b;
    logic [3*COORD_W-1:0]        ctrl_c;
    logic [3*COORD_W-1:0]        ctrl_d;
    logic                        done;
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic signed [COORD_W-1:0]   point_z;
    logic signed [SLOPE_W-1:0]   slope_x;
    logic signed [SLOPE_W-1:0]   slope_y;
    logic signed [SLOPE_W-1:0]   slope_z;

    bezier_scoreboard curve_sb;
    int               items_accepted = 0;
    int               stall_cycles   = 0;

    cubic_bezier_point_tangent_top uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .t_param (t_param),
        .ctrl_a  (ctrl_a),
        .ctrl_b  (ctrl_b),
        .ctrl_c  (ctrl_c),
        .ctrl_d  (ctrl_d),
        .done    (done),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .slope_x (slope_x),
        .slope_y (slope_y),
        .slope_z (slope_z)
    );

    // 10 ns clock.
    always #5 clk = ~clk;

    // Monitor. Everything is sampled at the rising edge, before the block's own updates of
    // that edge take effect, so the values seen are exactly those the block acted on. A result
    // is checked before any item of the same edge is noted; a result always belongs to an item
    // accepted at an earlier edge, so the order makes no difference to the queue.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                curve_sb.check_curve_sample('{point: {point_z, point_y, point_x},
                                               slope: {slope_z, slope_y, slope_x}});
            if (start && !busy)
            begin
                curve_sb.predict_curve_sample(t_param, ctrl_a, ctrl_b, ctrl_c, ctrl_d);
                items_accepted++;
            end
        end
    end

    // Watchdog: counts cycles in which neither an item nor a result moves. Random gaps on
    // the sending side are short, so a count this large means the block has hung.
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || (rst_n && done))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("cubic_bezier_point_tangent_top verification failed");
            $finish;
        end
    end

    // Packs three signed coordinates into one control point, x in the low bits.
    function automatic logic [3*COORD_W-1:0] mk_point(input int x, input int y, input int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input coord_mode_e mode);
        logic [COORD_W-1:0] v;
        case (mode)
            CM_FULL:
                v = 16'($urandom);
            CM_EXTREME:
                case ($urandom_range(0, 3))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            default:
                v = 16'($urandom_range(0, 16) - 8);
        endcase
        return v;
    endfunction

    // A random control point; the drawing mode is chosen afresh for every point.
    function automatic logic [3*COORD_W-1:0] pick_point();
        coord_mode_e mode;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 50)
            mode = CM_FULL;
        else if (r < 75)
            mode = CM_EXTREME;
        else
            mode = CM_SMALL;
        return {pick_coord(mode), pick_coord(mode), pick_coord(mode)};
    endfunction

    // The curve parameter leans towards the ends of the curve, its midpoint and values
    // above 1.0, which the block must clamp.
    function automatic logic [FRAC_W:0] pick_param();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return 17'(ONE_Q);
        else if (r < 28)
            return 17'($urandom_range(ONE_Q + 1, 2 * ONE_Q - 1));
        else if (r < 35)
            return 17'(ONE_Q / 2);
        return 17'($urandom_range(0, ONE_Q));
    endfunction

    // Presents one item from a falling edge and holds it until a rising edge accepts it.
    // Before the item, start may be dropped for a random number of cycles (about one in
    // three). Start is assigned only once per falling edge, so back-to-back items keep it high.
    task automatic send_sample(input logic [FRAC_W:0] tq,
                               input logic [3*COORD_W-1:0] p1, p2, p3, p4,
                               input bit may_idle);
        @(negedge clk);
        while (may_idle && $urandom_range(0, 99) < 32)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start   = 1'b1;
        t_param = tq;
        ctrl_a  = p1;
        ctrl_b  = p2;
        ctrl_c  = p3;
        ctrl_d  = p4;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        int directed_count;
        logic [3*COORD_W-1:0] zero_pt;
        logic [3*COORD_W-1:0] max_pt;
        logic [3*COORD_W-1:0] min_pt;

        zero_pt  = '0;
        max_pt   = mk_point(32767, 32767, 32767);
        min_pt   = mk_point(-32768, -32768, -32768);
        curve_sb = new();

        // Every input is known from time zero; reset is asserted once and released at a falling edge.
        rst_n   = 1'b0;
        start   = 1'b0;
        t_param = '0;
        ctrl_a  = '0;
        ctrl_b  = '0;
        ctrl_c  = '0;
        ctrl_d  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items. At t = 0 the point is the first control point and at t = 1 the
        // last one; the tangent reaches its extremes there when neighbouring points sit at
        // opposite ends of the coordinate range.
        send_sample(17'd0, max_pt, zero_pt, zero_pt, zero_pt, 1'b0);
        send_sample(17'(ONE_Q), zero_pt, zero_pt, zero_pt, min_pt, 1'b0);
        send_sample(17'd0, min_pt, max_pt, zero_pt, zero_pt, 1'b0);
        send_sample(17'd0, max_pt, min_pt, zero_pt, zero_pt, 1'b0);
        send_sample(17'(ONE_Q), zero_pt, zero_pt, max_pt, min_pt, 1'b0);
        send_sample(17'(ONE_Q), zero_pt, zero_pt, min_pt, max_pt, 1'b0);
        // At t = 0.5 these points give exact halves: ties must round towards plus infinity,
        // for positive and negative values alike, on both the point and the tangent.
        send_sample(17'(ONE_Q / 2), mk_point(4, -4, 12), zero_pt, zero_pt, zero_pt, 1'b1);
        send_sample(17'(ONE_Q / 2), zero_pt, zero_pt, zero_pt, mk_point(2, -2, 6), 1'b1);
        send_sample(17'(ONE_Q / 2), mk_point(-12, 20, -20), zero_pt, zero_pt,
                    mk_point(-2, 2, -6), 1'b1);
        // Parameters above 1.0 are clamped, up to the widest value the port can carry.
        send_sample(17'(ONE_Q + 1), mk_point(100, -200, 300), max_pt, min_pt,
                    mk_point(-7, 7, 0), 1'b1);
        send_sample(17'h1FFFF, min_pt, max_pt, max_pt, mk_point(1, 2, 3), 1'b1);
        // Smallest steps away from either end, and a third, where one tangent weight nearly vanishes.
        send_sample(17'd1, max_pt, min_pt, max_pt, min_pt, 1'b1);
        send_sample(17'(ONE_Q - 1), min_pt, max_pt, min_pt, max_pt, 1'b1);
        send_sample(17'd21845, mk_point(1000, -1000, 5), mk_point(-3, 9, 27),
                    mk_point(30000, -30000, 77), mk_point(-1, 1, -1), 1'b1);
        // All points equal at either extreme, alternating bit patterns in every field, and mixed extremes.
        send_sample(17'd12345, max_pt, max_pt, max_pt, max_pt, 1'b1);
        send_sample(17'd54321, min_pt, min_pt, min_pt, min_pt, 1'b1);
        send_sample(17'h0AAAA, {3{16'h5555}}, {3{16'hAAAA}}, {3{16'h5555}},
                    {3{16'hAAAA}}, 1'b1);
        send_sample(17'h15555, {3{16'hAAAA}}, {3{16'h5555}}, {3{16'hAAAA}},
                    {3{16'h5555}}, 1'b1);
        send_sample(17'(ONE_Q / 2), max_pt, min_pt, min_pt, max_pt, 1'b1);
        send_sample(17'(ONE_Q / 4), min_pt, max_pt, max_pt, min_pt, 1'b1);
        directed_count = 20;

        // Random items. A block of a hundred in the middle is sent back to back, so that
        // the pipeline runs full for a while; elsewhere gaps land on every pipeline stage.
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_sample(pick_param(), pick_point(), pick_point(), pick_point(), pick_point(),
                        !(i >= 150 && i < 250));
        @(negedge clk);
        start = 1'b0;

        // Drain: wait for every outstanding result, then a little longer than the pipeline
        // depth, so that a stray extra strobe would still be caught.
        while (curve_sb.expected_samples.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 8) @(posedge clk);
        if (curve_sb.expected_samples.size() != 0)
        begin
            $error("%0d results never arrived", curve_sb.expected_samples.size());
            curve_sb.failures++;
        end

        $display("Sent %0d items (%0d directed: curve ends, rounding ties, clamped t, extreme",
                 items_accepted, directed_count);
        $display("points; the rest random); %0d results checked, %0d mismatches.",
                 curve_sb.checked, curve_sb.failures);
        if (curve_sb.failures == 0)
            $display("cubic_bezier_point_tangent_top verification clean");
        else
            $display("cubic_bezier_point_tangent_top verification failed");
        $finish;
    end

endmodule
